>>> design/vog_pkg.sv
// Shared constants, codes and types of the voxel occupancy grid.
// No dependencies; vog_axis and voxel_occupancy_grid_unit refer to it by scoped names.
package vog_pkg;

	// field widths
	localparam int PT_W       = 32;
	localparam int INV_W      = 24;
	localparam int SZXY_W     = 6;
	localparam int SZZ_W      = 5;
	localparam int CELLXY_W   = 5;
	localparam int CELLZ_W    = 4;
	localparam int OUT_IDX_W  = 16;
	localparam int CLASS_W    = 2;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// index arithmetic: 33-bit difference times 25-bit signed factor, Q.32 product
	localparam int DIFF_W  = PT_W + 1;
	localparam int PROD_W  = DIFF_W + INV_W + 1;
	localparam int FRAC_SH = 32;
	localparam int IDX_W   = PROD_W - FRAC_SH;

	// commands
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MARK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

	// voxel codes
	localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_FREE    = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_OCC     = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_RES  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z   = 3'd6;

	localparam logic [INV_W-1:0] INV_RES_RST = 24'd655360;

	// stage enables of one axis index unit
	typedef struct packed {
		logic diff_en;
		logic mul_en;
		logic idx_en;
	} axis_ctl_t;

endpackage

>>> design/vog_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module vog_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/vog_axis.sv
// One axis of the point-to-voxel index: difference, scale, truncate toward zero.
// Depends on vog_pkg for widths and the stage-enable struct.
module vog_axis (
	input  logic                                   clk,
	input  vog_pkg::axis_ctl_t                     ctl,
	input  logic signed [vog_pkg::PT_W-1:0]        point,
	input  logic signed [vog_pkg::PT_W-1:0]        origin,
	input  logic        [vog_pkg::INV_W-1:0]       inv,
	output logic        [vog_pkg::IDX_W-1:0]       idx,
	output logic signed [vog_pkg::OUT_IDX_W-1:0]   idx_sat
);

	localparam logic signed [vog_pkg::PROD_W-1:0] ROUND_ADD =
		vog_pkg::PROD_W'((64'd1 << vog_pkg::FRAC_SH) - 64'd1);
	localparam logic signed [vog_pkg::IDX_W-1:0] SAT_HI = vog_pkg::IDX_W'(32767);
	localparam logic signed [vog_pkg::IDX_W-1:0] SAT_LO = vog_pkg::IDX_W'(-32768);

	logic signed [vog_pkg::DIFF_W-1:0]  diff_s1;
	logic signed [vog_pkg::PROD_W-1:0]  prod_s2;
	logic signed [vog_pkg::PROD_W-1:0]  prod_adj;
	logic signed [vog_pkg::IDX_W-1:0]   idx_s3;
	logic signed [vog_pkg::INV_W:0]     inv_s;

	assign inv_s = $signed({1'b0, inv});

	// negative products round up so the shift truncates toward zero
	assign prod_adj = prod_s2[vog_pkg::PROD_W-1] ? prod_s2 + ROUND_ADD : prod_s2;

	always_ff @(posedge clk) begin
		if (ctl.diff_en) begin
			diff_s1 <= {point[vog_pkg::PT_W-1], point} - {origin[vog_pkg::PT_W-1], origin};
		end
		if (ctl.mul_en) begin
			prod_s2 <= vog_pkg::PROD_W'(diff_s1) * vog_pkg::PROD_W'(inv_s);
		end
		if (ctl.idx_en) begin
			idx_s3 <= prod_adj[vog_pkg::PROD_W-1:vog_pkg::FRAC_SH];
		end
	end

	always_comb begin
		if (idx_s3 > SAT_HI) begin
			idx_sat = SAT_HI[vog_pkg::OUT_IDX_W-1:0];
		end else if (idx_s3 < SAT_LO) begin
			idx_sat = SAT_LO[vog_pkg::OUT_IDX_W-1:0];
		end else begin
			idx_sat = idx_s3[vog_pkg::OUT_IDX_W-1:0];
		end
	end

	assign idx = idx_s3;

endmodule

>>> design/voxel_occupancy_grid_unit.sv
// Voxel occupancy grid: 2-bit voxel codes in one synchronous RAM, read-modify by command.
// A mark steps through MUL, IDX, CHECK and ACCESS, a read through CHECK, ACCESS and RDATA;
// one command at a time; busy falls with the registered done strobe, a no-op leaves it low,
// and requests are paced by the index pipeline, the one RAM port and the clear sweep that
// writes one voxel per cycle. Reset: configuration and control registers take reset values
// and a clearing pass writes all MAX_X*MAX_Y*MAX_Z voxels unknown while busy is high;
// config writes are taken at any time.
module voxel_occupancy_grid_unit #(
	parameter int MAX_X = 32,
	parameter int MAX_Y = 32,
	parameter int MAX_Z = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// command channel
	input  logic                                  start,
	output logic                                  busy,
	input  logic [vog_pkg::CMD_W-1:0]             command,
	input  logic signed [vog_pkg::PT_W-1:0]       point_x,
	input  logic signed [vog_pkg::PT_W-1:0]       point_y,
	input  logic signed [vog_pkg::PT_W-1:0]       point_z,
	input  logic [vog_pkg::CELLXY_W-1:0]          cell_x,
	input  logic [vog_pkg::CELLXY_W-1:0]          cell_y,
	input  logic [vog_pkg::CELLZ_W-1:0]           cell_z,
	// result
	output logic                                  done,
	output logic                                  in_bounds,
	output logic [vog_pkg::CLASS_W-1:0]           cell_class,
	output logic signed [vog_pkg::OUT_IDX_W-1:0]  index_x,
	output logic signed [vog_pkg::OUT_IDX_W-1:0]  index_y,
	output logic signed [vog_pkg::OUT_IDX_W-1:0]  index_z,
	// configuration
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [vog_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [vog_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW    = (MAX_X > 1) ? $clog2(MAX_X) : 1;
	localparam int YW    = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
	localparam int ZW    = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
	localparam int YZW   = (MAX_Y * MAX_Z > 1) ? $clog2(MAX_Y * MAX_Z) : 1;
	localparam int IW    = vog_pkg::IDX_W;

	typedef enum logic [6:0] {
		ST_SWEEP  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_MUL    = 7'b0000100,
		ST_IDX    = 7'b0001000,
		ST_CHECK  = 7'b0010000,
		ST_ACCESS = 7'b0100000,
		ST_RDATA  = 7'b1000000
	} state_t;

	state_t state_q;
	logic   accept;

	// configuration registers
	logic signed [vog_pkg::PT_W-1:0]   origin_x_q, origin_y_q, origin_z_q;
	logic        [vog_pkg::INV_W-1:0]  inv_res_q;
	logic        [vog_pkg::SZXY_W-1:0] size_x_q, size_y_q;
	logic        [vog_pkg::SZZ_W-1:0]  size_z_q;

	// request registers
	logic [vog_pkg::CMD_W-1:0]    cmd_q;
	logic [vog_pkg::CELLXY_W-1:0] cell_x_q, cell_y_q;
	logic [vog_pkg::CELLZ_W-1:0]  cell_z_q;

	// sweep
	logic [AW-1:0]                sweep_cnt_q;
	logic [vog_pkg::CLASS_W-1:0]  fill_q;
	logic                         report_q;
	logic                         sweep_last;

	// index units
	vog_pkg::axis_ctl_t                  axis_ctl;
	logic [IW-1:0]                       idx_x, idx_y, idx_z;
	logic signed [vog_pkg::OUT_IDX_W-1:0] sat_x, sat_y, sat_z;

	// bounds and address
	logic [IW-1:0]   chk_x, chk_y, chk_z;
	logic [IW-1:0]   eff_x, eff_y, eff_z;
	logic            chk_ok;
	logic [XW-1:0]   x_s4;
	logic [YZW-1:0]  yz_s4;
	logic            ok_s4;
	logic [AW-1:0]   acc_addr;

	// RAM port
	logic                        ram_we, ram_re;
	logic [AW-1:0]               ram_addr;
	logic [vog_pkg::CLASS_W-1:0] ram_wdata, ram_rdata;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			inv_res_q  <= vog_pkg::INV_RES_RST;
			size_x_q   <= vog_pkg::SZXY_W'(32);
			size_y_q   <= vog_pkg::SZXY_W'(32);
			size_z_q   <= vog_pkg::SZZ_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				vog_pkg::REG_ORIGIN_X: origin_x_q <= $signed(cfg_data);
				vog_pkg::REG_ORIGIN_Y: origin_y_q <= $signed(cfg_data);
				vog_pkg::REG_ORIGIN_Z: origin_z_q <= $signed(cfg_data);
				vog_pkg::REG_INV_RES:  inv_res_q  <= cfg_data[vog_pkg::INV_W-1:0];
				vog_pkg::REG_SIZE_X:   size_x_q   <= cfg_data[vog_pkg::SZXY_W-1:0];
				vog_pkg::REG_SIZE_Y:   size_y_q   <= cfg_data[vog_pkg::SZXY_W-1:0];
				vog_pkg::REG_SIZE_Z:   size_z_q   <= cfg_data[vog_pkg::SZZ_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= command;
			cell_x_q <= cell_x;
			cell_y_q <= cell_y;
			cell_z_q <= cell_z;
		end
	end

	assign axis_ctl.diff_en = accept;
	assign axis_ctl.mul_en  = (state_q == ST_MUL);
	assign axis_ctl.idx_en  = (state_q == ST_IDX);

	vog_axis u_axis_x (
		.clk(clk), .ctl(axis_ctl), .point(point_x), .origin(origin_x_q),
		.inv(inv_res_q), .idx(idx_x), .idx_sat(sat_x)
	);
	vog_axis u_axis_y (
		.clk(clk), .ctl(axis_ctl), .point(point_y), .origin(origin_y_q),
		.inv(inv_res_q), .idx(idx_y), .idx_sat(sat_y)
	);
	vog_axis u_axis_z (
		.clk(clk), .ctl(axis_ctl), .point(point_z), .origin(origin_z_q),
		.inv(inv_res_q), .idx(idx_z), .idx_sat(sat_z)
	);

	// a size above its maximum acts as the maximum
	assign eff_x = (IW'(size_x_q) > IW'(MAX_X)) ? IW'(MAX_X) : IW'(size_x_q);
	assign eff_y = (IW'(size_y_q) > IW'(MAX_Y)) ? IW'(MAX_Y) : IW'(size_y_q);
	assign eff_z = (IW'(size_z_q) > IW'(MAX_Z)) ? IW'(MAX_Z) : IW'(size_z_q);

	assign chk_x = (cmd_q == vog_pkg::CMD_MARK) ? idx_x : IW'(cell_x_q);
	assign chk_y = (cmd_q == vog_pkg::CMD_MARK) ? idx_y : IW'(cell_y_q);
	assign chk_z = (cmd_q == vog_pkg::CMD_MARK) ? idx_z : IW'(cell_z_q);

	assign chk_ok = !chk_x[IW-1] && !chk_y[IW-1] && !chk_z[IW-1] &&
		(chk_x < eff_x) && (chk_y < eff_y) && (chk_z < eff_z);

	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			x_s4  <= chk_x[XW-1:0];
			yz_s4 <= YZW'(32'(chk_y[YW-1:0]) + 32'(MAX_Y) * 32'(chk_z[ZW-1:0]));
			ok_s4 <= chk_ok;
		end
	end

	assign acc_addr = AW'(32'(x_s4) + 32'(MAX_X) * 32'(yz_s4));

	assign sweep_last = (sweep_cnt_q == AW'(DEPTH - 1));

	assign ram_addr  = (state_q == ST_SWEEP) ? sweep_cnt_q : acc_addr;
	assign ram_wdata = (state_q == ST_SWEEP) ? fill_q : vog_pkg::CLASS_OCC;
	assign ram_we    = (state_q == ST_SWEEP) ||
		((state_q == ST_ACCESS) && (cmd_q == vog_pkg::CMD_MARK) && ok_s4);
	assign ram_re    = (state_q == ST_ACCESS) && (cmd_q == vog_pkg::CMD_READ) && ok_s4;

	vog_ram #(
		.WIDTH(vog_pkg::CLASS_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk(clk), .we(ram_we), .re(ram_re), .addr(ram_addr),
		.wdata(ram_wdata), .rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			sweep_cnt_q <= '0;
			fill_q      <= vog_pkg::CLASS_UNKNOWN;
			report_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					if (sweep_last) begin
						sweep_cnt_q <= '0;
						state_q     <= ST_IDLE;
					end else begin
						sweep_cnt_q <= sweep_cnt_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (command)
							vog_pkg::CMD_CLEAR: begin
								fill_q   <= vog_pkg::CLASS_FREE;
								report_q <= 1'b1;
								state_q  <= ST_SWEEP;
							end
							vog_pkg::CMD_MARK: state_q <= ST_MUL;
							vog_pkg::CMD_READ: state_q <= ST_CHECK;
							default: ;
						endcase
					end
				end
				ST_MUL:   state_q <= ST_IDX;
				ST_IDX:   state_q <= ST_CHECK;
				ST_CHECK: state_q <= ST_ACCESS;
				ST_ACCESS: begin
					if (cmd_q == vog_pkg::CMD_MARK) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RDATA;
					end
				end
				ST_RDATA: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// strobe: end of a reported sweep, no-op taken, mark access finished, read data back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ((state_q == ST_SWEEP) && sweep_last && report_q) ||
				(accept && (command == vog_pkg::CMD_NOP)) ||
				((state_q == ST_ACCESS) && (cmd_q == vog_pkg::CMD_MARK)) ||
				(state_q == ST_RDATA);
		end
	end

	// result payload; zero for clear and no-op
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) || (state_q == ST_SWEEP)) begin
			in_bounds  <= 1'b0;
			cell_class <= vog_pkg::CLASS_UNKNOWN;
			index_x    <= '0;
			index_y    <= '0;
			index_z    <= '0;
		end else if ((state_q == ST_ACCESS) && (cmd_q == vog_pkg::CMD_MARK)) begin
			in_bounds  <= ok_s4;
			cell_class <= vog_pkg::CLASS_UNKNOWN;
			index_x    <= sat_x;
			index_y    <= sat_y;
			index_z    <= sat_z;
		end else if (state_q == ST_RDATA) begin
			in_bounds  <= ok_s4;
			cell_class <= ok_s4 ? ram_rdata : vog_pkg::CLASS_UNKNOWN;
			index_x    <= '0;
			index_y    <= '0;
			index_z    <= '0;
		end
	end

	a_store_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_SWEEP || state_q == ST_ACCESS))
		else $error("store written outside sweep or access");

	a_mark_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACCESS && cmd_q == vog_pkg::CMD_MARK) |=>
			(done && in_bounds == $past(ok_s4)))
		else $error("mark result does not match bounds check");

	a_class_needs_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cell_class != vog_pkg::CLASS_UNKNOWN) |-> in_bounds)
		else $error("voxel class reported for an out-of-bounds request");

	a_sweep_rest: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SWEEP) |-> (sweep_cnt_q == '0))
		else $error("sweep counter not parked outside sweep");

endmodule
